// ===== rtl/core/ide_card_bus_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// ide_card_bus_decoder_defines.svh
// Assertion macros for the IDE card bus decoder
// ----------------------------------------------------------------------------
`ifndef IDE_CARD_BUS_DECODER_DEFINES_SVH
`define IDE_CARD_BUS_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define ICBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent holds, consequent holds in the following cycle
`define ICBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ICBD_ASSERT_SAME(lbl, ante, cons, msg)
`define ICBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/icbd_pkg.sv =====
// ----------------------------------------------------------------------------
// icbd_pkg
// Types and constants shared by the IDE card bus decoder modules
// ----------------------------------------------------------------------------
package icbd_pkg;

  localparam int SRAM_PAGE_BYTES  = 8192;
  localparam int CLOCK_PAGE_BYTES = 32;
  localparam int CREG_DEPTH       = 64;

  // control bit positions
  localparam int BIT_WINDOW       = 1;
  localparam int BIT_PAGE_SWITCH  = 2;
  localparam int BIT_PAGE_FORCE   = 3;
  localparam int BIT_WRITE_PROT   = 5;
  localparam int BIT_DRIVE_RESET  = 7;

  typedef enum logic [1:0] {
    KIND_CTRL_RD = 2'd0,
    KIND_CTRL_WR = 2'd1,
    KIND_MEM_RD  = 2'd2,
    KIND_MEM_WR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } access_t;

  typedef enum logic [1:0] {
    RSRC_REG  = 2'd0,
    RSRC_CRAM = 2'd1,
    RSRC_CREG = 2'd2,
    RSRC_SRAM = 2'd3
  } rsrc_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } stat_t;

endpackage

// ===== rtl/core/icbd_in_if.sv =====
// ----------------------------------------------------------------------------
// icbd_in_if
// Bus access channel into the decoder
// ----------------------------------------------------------------------------
interface icbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] address;
  logic [7:0]  write_value;
  logic        drive_irq;
  logic [15:0] drive_read_word;

  modport source (output valid, kind, address, write_value, drive_irq, drive_read_word,
                  input ready);
  modport sink (input valid, kind, address, write_value, drive_irq, drive_read_word,
                output ready);
endinterface

// ===== rtl/core/icbd_out_if.sv =====
// ----------------------------------------------------------------------------
// icbd_out_if
// Result channel out of the decoder
// ----------------------------------------------------------------------------
interface icbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic [1:0]  drive_access;
  logic        alternate_set;
  logic [2:0]  drive_register;
  logic [15:0] drive_write_word;
  logic        drive_reset_pulse;

  modport source (output valid, read_value, drive_access, alternate_set, drive_register,
                  drive_write_word, drive_reset_pulse, input ready);
  modport sink (input valid, read_value, drive_access, alternate_set, drive_register,
                drive_write_word, drive_reset_pulse, output ready);
endinterface

// ===== rtl/core/ide_card_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// ide_card_bus_decoder
// Bus decoder for an IDE expansion card with paged SRAM and clock chip
// ----------------------------------------------------------------------------
//  channel   dir   handshake        carries
//  in_ch     in    valid/ready      kind, address, write_value, drive state
//  out_ch    out   valid/ready      read byte and drive access word
//  cfg_*     in    write enable     register window dip switch
//
//  a word is accepted, then passes through an execute state in which the
//  SRAM, clock RAM or clock register RAM port is read or written once
//  the result leaves from the registered read data, while the next word enters
//  a result held by out_ch stalls the sequencer in its delivery cycle
//  reset clears the control state and the clock register valid bits at once;
//  SRAM and clock RAM are not cleared
module ide_card_bus_decoder #(
  parameter int SRAM_PAGES      = 64,
  parameter int CLOCK_RAM_PAGES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  icbd_in_if.sink    in_ch,
  icbd_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  icbd_pkg::cmd_t  cmd;
  icbd_pkg::stat_t stat;
  logic            in_ready;

  icbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  icbd_datapath #(
    .SRAM_PAGES      (SRAM_PAGES),
    .CLOCK_RAM_PAGES (CLOCK_RAM_PAGES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_kind               (in_ch.kind),
    .in_address            (in_ch.address),
    .in_write_value        (in_ch.write_value),
    .in_drive_irq          (in_ch.drive_irq),
    .in_drive_read_word    (in_ch.drive_read_word),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_read_value        (out_ch.read_value),
    .out_drive_access      (out_ch.drive_access),
    .out_alternate_set     (out_ch.alternate_set),
    .out_drive_register    (out_ch.drive_register),
    .out_drive_write_word  (out_ch.drive_write_word),
    .out_drive_reset_pulse (out_ch.drive_reset_pulse)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== rtl/core/icbd_ram.sv =====
// ----------------------------------------------------------------------------
// icbd_ram
// Single-port synchronous RAM with registered read
// ----------------------------------------------------------------------------
module icbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/icbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// icbd_ctrl
// Sequencer: accept a word, execute it, deliver the result
// ----------------------------------------------------------------------------
`include "ide_card_bus_decoder_defines.svh"

module icbd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  icbd_pkg::stat_t stat,
  output icbd_pkg::cmd_t  cmd
);

  icbd_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      icbd_pkg::ST_IDLE: begin
        if (accept) state_nxt = icbd_pkg::ST_EXEC;
      end
      icbd_pkg::ST_EXEC: begin
        state_nxt = icbd_pkg::ST_DONE;
      end
      icbd_pkg::ST_DONE: begin
        if (stat.slot_free) begin
          state_nxt = accept ? icbd_pkg::ST_EXEC : icbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = icbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      icbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      icbd_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      icbd_pkg::ST_DONE: begin
        // next word may come in as the finished one leaves
        in_ready = stat.slot_free;
        cmd.load = stat.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icbd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ICBD_ASSERT_NEXT(a_accept_exec, accept, state_r == icbd_pkg::ST_EXEC, "accepted word not executed")
  `ICBD_ASSERT_NEXT(a_exec_done, state_r == icbd_pkg::ST_EXEC, state_r == icbd_pkg::ST_DONE, "execute not followed by done")
  `ICBD_ASSERT_NEXT(a_hold_done, state_r == icbd_pkg::ST_DONE && !stat.slot_free, state_r == icbd_pkg::ST_DONE, "result lost while output held")
  `ICBD_ASSERT_SAME(a_load_free, cmd.load, stat.slot_free && state_r == icbd_pkg::ST_DONE, "result loaded into full slot")

endmodule

// ===== rtl/core/icbd_datapath.sv =====
// ----------------------------------------------------------------------------
// icbd_datapath
// Decoder state, memories, address decode and result register
// ----------------------------------------------------------------------------
module icbd_datapath #(
  parameter int SRAM_PAGES      = 64,
  parameter int CLOCK_RAM_PAGES = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  icbd_pkg::cmd_t  cmd,
  output icbd_pkg::stat_t stat,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic [1:0]      in_kind,
  input  logic [12:0]     in_address,
  input  logic [7:0]      in_write_value,
  input  logic            in_drive_irq,
  input  logic [15:0]     in_drive_read_word,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_read_value,
  output logic [1:0]      out_drive_access,
  output logic            out_alternate_set,
  output logic [2:0]      out_drive_register,
  output logic [15:0]     out_drive_write_word,
  output logic            out_drive_reset_pulse
);

  localparam int PAGE_W  = $clog2(SRAM_PAGES);
  localparam int SRAM_D  = SRAM_PAGES * icbd_pkg::SRAM_PAGE_BYTES;
  localparam int SRAM_AW = $clog2(SRAM_D);
  localparam int CRAM_D  = CLOCK_RAM_PAGES * icbd_pkg::CLOCK_PAGE_BYTES;
  localparam int CRAM_AW = $clog2(CRAM_D);
  localparam int CREG_AW = $clog2(icbd_pkg::CREG_DEPTH);

  // rounded-up 2^16 / divisor, exact for any 8-bit value and divisor up to 256
  localparam int PAGE_RECIP  = (65536 + SRAM_PAGES - 1) / SRAM_PAGES;
  localparam int CPAGE_RECIP = (65536 + CLOCK_RAM_PAGES - 1) / CLOCK_RAM_PAGES;

  // remainder by reciprocal multiplication, quotient in the top byte
  function automatic logic [7:0] mod8(input logic [7:0] v, input logic [16:0] m,
                                      input logic [8:0] d);
    logic [23:0] prod;
    logic [16:0] qd;
    prod = {16'd0, v} * {7'd0, m};
    qd   = {9'd0, prod[23:16]} * {8'd0, d};
    return v - qd[7:0];
  endfunction

  // captured word
  icbd_pkg::kind_t it_kind_r;
  logic [12:0]     it_addr_r;
  logic [7:0]      it_data_r;
  logic            it_irq_r;
  logic [15:0]     it_dword_r;

  // architectural state
  logic              cfg_sw_r;
  logic              win_sel_r, win_sel_nxt;
  logic [7:2]        ctrl_r, ctrl_nxt;
  logic [PAGE_W-1:0] sram_page_r, sram_page_nxt;
  logic [6:0]        cram_page_r, cram_page_nxt;
  logic [5:0]        creg_sel_r, creg_sel_nxt;
  logic [7:0]        hi_latch_r, hi_latch_nxt;
  logic [7:0]        lo_latch_r, lo_latch_nxt;
  logic [icbd_pkg::CREG_DEPTH-1:0] creg_valid_r, creg_valid_nxt;

  // result of the execute cycle
  icbd_pkg::rsrc_t src_r, src_nxt;
  logic [7:0]      rv_r, rv_nxt;
  logic [1:0]      acc_r, acc_nxt;
  logic            alt_r, alt_nxt;
  logic [2:0]      reg_r, reg_nxt;
  logic [15:0]     wword_r, wword_nxt;
  logic            pulse_r, pulse_nxt;
  logic            creg_vld_r;

  // output register
  logic        out_valid_r;
  logic [7:0]  o_rv_r;
  logic [1:0]  o_acc_r;
  logic        o_alt_r;
  logic [2:0]  o_reg_r;
  logic [15:0] o_wword_r;
  logic        o_pulse_r;

  // memory ports
  logic               sram_we, sram_re, cram_we, cram_re, creg_we, creg_re;
  logic [SRAM_AW-1:0] sram_addr;
  logic [CRAM_AW-1:0] cram_addr;
  logic [7:0]         sram_rdata, cram_rdata, creg_rdata;
  logic [7:0]         rd_mux;

  // decode helpers
  logic        wr, regs, alt_set;
  logic [2:0]  bitno;
  logic [1:0]  group;
  logic [7:0]  page_mod, page_cur, cpage_mod;
  logic [20:0] sram_full;
  logic [11:0] cram_full;
  logic [15:0] w;

  always_comb begin
    win_sel_nxt    = win_sel_r;
    ctrl_nxt       = ctrl_r;
    sram_page_nxt  = sram_page_r;
    cram_page_nxt  = cram_page_r;
    creg_sel_nxt   = creg_sel_r;
    hi_latch_nxt   = hi_latch_r;
    lo_latch_nxt   = lo_latch_r;
    creg_valid_nxt = creg_valid_r;
    src_nxt        = icbd_pkg::RSRC_REG;
    rv_nxt         = '0;
    acc_nxt        = icbd_pkg::ACC_NONE;
    alt_nxt        = 1'b0;
    reg_nxt        = '0;
    wword_nxt      = '0;
    pulse_nxt      = 1'b0;
    sram_we        = 1'b0;
    sram_re        = 1'b0;
    cram_we        = 1'b0;
    cram_re        = 1'b0;
    creg_we        = 1'b0;
    creg_re        = 1'b0;
    w              = '0;

    wr      = (it_kind_r == icbd_pkg::KIND_MEM_WR);
    bitno   = it_addr_r[2:0];
    group   = it_addr_r[6:5];
    alt_set = group[0];
    regs    = (it_addr_r[12:8] == 5'd0) && (win_sel_r == cfg_sw_r);

    // a page switch takes effect for the access that makes it
    page_mod = mod8(it_addr_r[8:1], 17'(PAGE_RECIP), 9'(SRAM_PAGES));
    if (wr && ctrl_r[icbd_pkg::BIT_PAGE_SWITCH]) begin
      page_cur = page_mod;
    end else begin
      page_cur = 8'(sram_page_r);
    end
    if (!(ctrl_r[icbd_pkg::BIT_PAGE_FORCE] || it_addr_r[12])) begin
      page_cur = '0;
    end
    sram_full = {page_cur, it_addr_r};
    sram_addr = sram_full[SRAM_AW-1:0];

    cpage_mod = mod8({1'b0, cram_page_r}, 17'(CPAGE_RECIP), 9'(CLOCK_RAM_PAGES));
    cram_full = {cpage_mod[6:0], it_addr_r[4:0]};
    cram_addr = cram_full[CRAM_AW-1:0];

    if (cmd.exec) begin
      case (it_kind_r)
        icbd_pkg::KIND_CTRL_RD: begin
          rv_nxt = {ctrl_r, cfg_sw_r, ~it_irq_r};
        end
        icbd_pkg::KIND_CTRL_WR: begin
          if (bitno == 3'(icbd_pkg::BIT_WINDOW)) begin
            win_sel_nxt = |it_data_r;
          end else if (bitno >= 3'(icbd_pkg::BIT_PAGE_SWITCH)) begin
            ctrl_nxt[bitno] = |it_data_r;
            pulse_nxt = (bitno == 3'(icbd_pkg::BIT_DRIVE_RESET)) && (|it_data_r);
          end
        end
        default: begin
          if (wr && ctrl_r[icbd_pkg::BIT_PAGE_SWITCH]) begin
            sram_page_nxt = page_mod[PAGE_W-1:0];
          end
          if (regs) begin
            case (group)
              2'd0: begin
                if (it_addr_r[7]) begin
                  if (wr) cram_page_nxt = it_data_r[6:0];
                  else rv_nxt = {1'b0, cram_page_r};
                end else begin
                  cram_we = wr;
                  cram_re = !wr;
                  if (!wr) src_nxt = icbd_pkg::RSRC_CRAM;
                end
              end
              2'd1: begin
                if (it_addr_r[4]) begin
                  creg_we = wr;
                  creg_re = !wr;
                  if (wr) creg_valid_nxt[creg_sel_r] = 1'b1;
                  else src_nxt = icbd_pkg::RSRC_CREG;
                end else begin
                  if (wr) creg_sel_nxt = it_data_r[5:0];
                  else rv_nxt = {2'b00, creg_sel_r};
                end
              end
              default: begin
                if (wr) begin
                  if (it_addr_r[0]) begin
                    lo_latch_nxt = it_data_r;
                  end else begin
                    acc_nxt   = icbd_pkg::ACC_WRITE;
                    alt_nxt   = alt_set;
                    reg_nxt   = it_addr_r[3:1];
                    wword_nxt = {it_data_r, lo_latch_r};
                  end
                end else begin
                  if (it_addr_r[0]) begin
                    // bit four on an odd read suppresses the drive access
                    if (!it_addr_r[4]) begin
                      w       = it_dword_r;
                      acc_nxt = icbd_pkg::ACC_READ;
                      alt_nxt = alt_set;
                      reg_nxt = it_addr_r[3:1];
                    end
                    hi_latch_nxt = w[15:8];
                    rv_nxt       = w[7:0];
                  end else begin
                    rv_nxt = hi_latch_r;
                  end
                end
              end
            endcase
          end else begin
            sram_we = wr && !ctrl_r[icbd_pkg::BIT_WRITE_PROT];
            sram_re = !wr;
            if (!wr) src_nxt = icbd_pkg::RSRC_SRAM;
          end
        end
      endcase
    end
  end

  icbd_ram #(.WIDTH(8), .DEPTH(SRAM_D)) u_sram (
    .clk(clk), .we(sram_we), .re(sram_re), .addr(sram_addr),
    .wdata(it_data_r), .rdata(sram_rdata)
  );

  icbd_ram #(.WIDTH(8), .DEPTH(CRAM_D)) u_cram (
    .clk(clk), .we(cram_we), .re(cram_re), .addr(cram_addr),
    .wdata(it_data_r), .rdata(cram_rdata)
  );

  icbd_ram #(.WIDTH(8), .DEPTH(icbd_pkg::CREG_DEPTH)) u_creg (
    .clk(clk), .we(creg_we), .re(creg_re), .addr(creg_sel_r[CREG_AW-1:0]),
    .wdata(it_data_r), .rdata(creg_rdata)
  );

  always_comb begin
    case (src_r)
      icbd_pkg::RSRC_CRAM: rd_mux = cram_rdata;
      icbd_pkg::RSRC_CREG: rd_mux = creg_vld_r ? creg_rdata : 8'h00;
      icbd_pkg::RSRC_SRAM: rd_mux = sram_rdata;
      default:             rd_mux = rv_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sw_r     <= 1'b1;
      win_sel_r    <= 1'b0;
      ctrl_r       <= '0;
      sram_page_r  <= '0;
      cram_page_r  <= '0;
      creg_sel_r   <= '0;
      hi_latch_r   <= '0;
      lo_latch_r   <= '0;
      creg_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) cfg_sw_r <= cfg_wdata;
      win_sel_r    <= win_sel_nxt;
      ctrl_r       <= ctrl_nxt;
      sram_page_r  <= sram_page_nxt;
      cram_page_r  <= cram_page_nxt;
      creg_sel_r   <= creg_sel_nxt;
      hi_latch_r   <= hi_latch_nxt;
      lo_latch_r   <= lo_latch_nxt;
      creg_valid_r <= creg_valid_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_kind_r  <= icbd_pkg::kind_t'(in_kind);
      it_addr_r  <= in_address;
      it_data_r  <= in_write_value;
      it_irq_r   <= in_drive_irq;
      it_dword_r <= in_drive_read_word;
    end
    if (cmd.exec) begin
      src_r      <= src_nxt;
      rv_r       <= rv_nxt;
      acc_r      <= acc_nxt;
      alt_r      <= alt_nxt;
      reg_r      <= reg_nxt;
      wword_r    <= wword_nxt;
      pulse_r    <= pulse_nxt;
      creg_vld_r <= creg_valid_r[creg_sel_r];
    end
    if (cmd.load) begin
      o_rv_r    <= rd_mux;
      o_acc_r   <= acc_r;
      o_alt_r   <= alt_r;
      o_reg_r   <= reg_r;
      o_wword_r <= wword_r;
      o_pulse_r <= pulse_r;
    end
  end

  assign stat.slot_free      = !out_valid_r || out_ready;
  assign out_valid             = out_valid_r;
  assign out_read_value        = o_rv_r;
  assign out_drive_access      = o_acc_r;
  assign out_alternate_set     = o_alt_r;
  assign out_drive_register    = o_reg_r;
  assign out_drive_write_word  = o_wword_r;
  assign out_drive_reset_pulse = o_pulse_r;

endmodule
